### hw/rtl/u8d_pkg.sv
// Shared types, constants and helpers for the UTF-8 stream decoder.
`timescale 1ns / 1ps

package u8d_pkg;

    localparam int CpWidth  = 31;
    localparam int LenWidth = 3;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BADLEAD  = 2'd1,
        ST_BADCONT  = 2'd2,
        ST_OVERLONG = 2'd3
    } status_t;

    // Decoder state carried from byte to byte.
    typedef struct packed {
        logic [CpWidth-1:0]  partial;
        logic [LenWidth-1:0] needed;
        logic [LenWidth-1:0] total;
    } dec_state_t;

    // One decoded result.
    typedef struct packed {
        logic [CpWidth-1:0]  code_point;
        logic [LenWidth-1:0] seq_length;
        status_t             status;
    } dec_result_t;

    // Smallest legal value for each sequence length.
    function automatic logic [CpWidth-1:0] min_value(input logic [LenWidth-1:0] len);
        logic [CpWidth-1:0] lim;
        case (len)
            3'd2:    lim = 31'h0000_0080;
            3'd3:    lim = 31'h0000_0800;
            3'd4:    lim = 31'h0001_0000;
            3'd5:    lim = 31'h0020_0000;
            3'd6:    lim = 31'h0400_0000;
            default: lim = '0;
        endcase
        return lim;
    endfunction

endpackage

### hw/rtl/u8d_step.sv
// Per-byte decode step: next state and optional result from one byte.
`timescale 1ns / 1ps

module u8d_step
(
    input  logic [7:0]           in_byte,
    input  u8d_pkg::dec_state_t  cur_state,
    output u8d_pkg::dec_state_t  next_state,
    output logic                 res_valid,
    output u8d_pkg::dec_result_t res
);

    logic [u8d_pkg::CpWidth-1:0]  shifted;
    logic [u8d_pkg::LenWidth-1:0] used;

    assign shifted = {cur_state.partial[u8d_pkg::CpWidth-7:0], in_byte[5:0]};
    assign used    = cur_state.total - cur_state.needed + 3'd1;

    always_comb
    begin
        next_state     = cur_state;
        res_valid      = 1'b0;
        res.code_point = '0;
        res.seq_length = 3'd1;
        res.status     = u8d_pkg::ST_OK;

        if (cur_state.needed == '0)
        begin
            // Lead byte: classify by leading ones.
            if (in_byte[7] == 1'b0)
            begin
                res_valid      = 1'b1;
                res.code_point = {{(u8d_pkg::CpWidth-8){1'b0}}, in_byte};
            end
            else if (in_byte[7:5] == 3'b110)
            begin
                next_state.partial = {{(u8d_pkg::CpWidth-5){1'b0}}, in_byte[4:0]};
                next_state.total   = 3'd2;
                next_state.needed  = 3'd1;
            end
            else if (in_byte[7:4] == 4'b1110)
            begin
                next_state.partial = {{(u8d_pkg::CpWidth-4){1'b0}}, in_byte[3:0]};
                next_state.total   = 3'd3;
                next_state.needed  = 3'd2;
            end
            else if (in_byte[7:3] == 5'b11110)
            begin
                next_state.partial = {{(u8d_pkg::CpWidth-3){1'b0}}, in_byte[2:0]};
                next_state.total   = 3'd4;
                next_state.needed  = 3'd3;
            end
            else if (in_byte[7:2] == 6'b111110)
            begin
                next_state.partial = {{(u8d_pkg::CpWidth-2){1'b0}}, in_byte[1:0]};
                next_state.total   = 3'd5;
                next_state.needed  = 3'd4;
            end
            else if (in_byte[7:1] == 7'b1111110)
            begin
                next_state.partial = {{(u8d_pkg::CpWidth-1){1'b0}}, in_byte[0]};
                next_state.total   = 3'd6;
                next_state.needed  = 3'd5;
            end
            else
            begin
                res_valid  = 1'b1;
                res.status = u8d_pkg::ST_BADLEAD;
            end
        end
        else if (in_byte[7:6] != 2'b10)
        begin
            // Drop the sequence; the failing byte is consumed.
            next_state     = '0;
            res_valid      = 1'b1;
            res.seq_length = used;
            res.status     = u8d_pkg::ST_BADCONT;
        end
        else if (cur_state.needed == 3'd1)
        begin
            // Last continuation: check for an overlong form.
            next_state     = '0;
            res_valid      = 1'b1;
            res.seq_length = cur_state.total;
            if (shifted < u8d_pkg::min_value(cur_state.total))
            begin
                res.status = u8d_pkg::ST_OVERLONG;
            end
            else
            begin
                res.code_point = shifted;
            end
        end
        else
        begin
            next_state.partial = shifted;
            next_state.needed  = cur_state.needed - 3'd1;
        end
    end

endmodule

### hw/rtl/utf8_stream_decoder_top.sv
// Top level of the UTF-8 stream decoder (1-to-6-byte form, 31-bit code points).
`timescale 1ns / 1ps

// Usage:
//   Input channel: one raw byte per beat on in_byte, qualified by in_valid;
//   the block raises in_stall to hold the sender off.
//   Output channel: one decoded result per beat on code_point, seq_length
//   and status, qualified by out_valid; the receiver raises out_stall.
//   A result appears when a sequence completes or an error is found:
//   status 0 ok, 1 invalid lead byte, 2 bad continuation byte, 3 overlong.
//   On any error code_point is zero and the decoder expects a lead byte.
//   Results are registered: the output (or skid) register takes a result
//   when the byte that completes (or breaks) its sequence is accepted.
//   Throughput: one byte per cycle while in_stall is low; the decode of each
//   byte is a single combinational step from decoder state to output register.
//   Stall: a two-entry output buffer (output register plus skid register)
//   keeps the input open for one more result while the receiver stalls;
//   in_stall rises only once both entries hold results.
//   Reset (rst_n low, asynchronous): the decoder returns to expecting a
//   lead byte, any partial sequence is dropped and both output entries
//   are emptied.
module utf8_stream_decoder_top
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [30:0] code_point,
    output logic [2:0]  seq_length,
    output logic [1:0]  status
);

    u8d_pkg::dec_state_t  state_reg;
    u8d_pkg::dec_state_t  state_next;
    u8d_pkg::dec_result_t step_res;
    logic                 step_valid;

    u8d_pkg::dec_result_t out_reg;
    u8d_pkg::dec_result_t skid_reg;
    logic                 out_valid_reg;
    logic                 skid_valid_reg;

    logic                 accept;
    logic                 push;
    logic                 pop;

    // Stall the input only when the skid entry is taken.
    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;
    assign push     = accept && step_valid;
    assign pop      = out_valid_reg && !out_stall;

    u8d_step u_step
    (
        .in_byte    (in_byte),
        .cur_state  (state_reg),
        .next_state (state_next),
        .res_valid  (step_valid),
        .res        (step_res)
    );

    // Decoder state: advance on every accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // Output valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || pop)
        begin
            out_valid_reg <= push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output payload: no reset needed.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (!out_valid_reg || pop)
        begin
            if (push)
            begin
                out_reg <= step_res;
            end
        end
        else if (push)
        begin
            skid_reg <= step_res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign code_point = out_reg.code_point;
    assign seq_length = out_reg.seq_length;
    assign status     = out_reg.status;

endmodule

### tb/utf8_stream_decoder_top_test.sv
// Testbench for the UTF-8 stream decoder: directed and random byte streams under back-pressure.
`timescale 1ns / 1ps

module utf8_stream_decoder_top_test;

    // Watchdog: cycles in a row with no beat on either channel before giving up.
    localparam int QUIET_LIMIT  = 5000;
    // Receiver hold-off used to fill the output buffer and back up the input.
    localparam int LONG_HOLD    = 250;
    // Cycles to keep watching after the last expected result.
    localparam int TAIL_CYCLES  = 20;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte    = 8'h00;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [30:0] code_point;
    logic [2:0]  seq_length;
    logic [1:0]  status;

    // Knobs set by each test phase, in percent of cycles.
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;

    // Long hold-off request: set by a test, picked up and cleared by the receiver.
    bit hold_request = 1'b0;
    int hold_left    = 0;

    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int bytes_sent     = 0;

    // Predicted decoder state, kept in step with every accepted input beat.
    logic [30:0] cp_partial = '0;
    logic [2:0]  bytes_left = '0;
    logic [2:0]  seq_total  = '0;

    // Results the block still owes us, oldest first.
    u8d_pkg::dec_result_t decodes_due[$];

    utf8_stream_decoder_top u_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .code_point (code_point),
        .seq_length (seq_length),
        .status     (status)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Advance the predicted decoder by one byte; queue a result if the byte
    // finishes a sequence, breaks one, or is a bad lead.
    task automatic decode_next_byte(input logic [7:0] b);
        u8d_pkg::dec_result_t r;
        logic [2:0]  len;
        logic [30:0] lowest;
        bit          emitted;
        r       = '0;
        len     = '0;
        lowest  = '0;
        emitted = 1'b0;
        if (bytes_left == 3'd0)
        begin
            // Expecting a lead byte: ASCII completes at once, a multi-byte
            // lead loads its payload bits, anything else is a bad lead.
            if (b[7] == 1'b0)
            begin
                emitted      = 1'b1;
                r.code_point = 31'(b);
                r.seq_length = 3'd1;
                r.status     = u8d_pkg::ST_OK;
            end
            else
            begin
                if (b[7:5] == 3'b110)
                begin
                    len = 3'd2;
                    cp_partial = 31'(b[4:0]);
                end
                else if (b[7:4] == 4'b1110)
                begin
                    len = 3'd3;
                    cp_partial = 31'(b[3:0]);
                end
                else if (b[7:3] == 5'b11110)
                begin
                    len = 3'd4;
                    cp_partial = 31'(b[2:0]);
                end
                else if (b[7:2] == 6'b111110)
                begin
                    len = 3'd5;
                    cp_partial = 31'(b[1:0]);
                end
                else if (b[7:1] == 7'b1111110)
                begin
                    len = 3'd6;
                    cp_partial = 31'(b[0]);
                end
                if (len == 3'd0)
                begin
                    emitted      = 1'b1;
                    r.code_point = '0;
                    r.seq_length = 3'd1;
                    r.status     = u8d_pkg::ST_BADLEAD;
                end
                else
                begin
                    seq_total  = len;
                    bytes_left = len - 3'd1;
                end
            end
        end
        else if (b[7:6] != 2'b10)
        begin
            // Broken sequence: the offending byte is consumed with it.
            emitted      = 1'b1;
            r.code_point = '0;
            r.seq_length = seq_total - bytes_left + 3'd1;
            r.status     = u8d_pkg::ST_BADCONT;
            cp_partial   = '0;
            bytes_left   = '0;
            seq_total    = '0;
        end
        else
        begin
            cp_partial = {cp_partial[24:0], b[5:0]};
            bytes_left = bytes_left - 3'd1;
            if (bytes_left == 3'd0)
            begin
                case (seq_total)
                    3'd2:    lowest = 31'h0000_0080;
                    3'd3:    lowest = 31'h0000_0800;
                    3'd4:    lowest = 31'h0001_0000;
                    3'd5:    lowest = 31'h0020_0000;
                    3'd6:    lowest = 31'h0400_0000;
                    default: lowest = '0;
                endcase
                emitted      = 1'b1;
                r.seq_length = seq_total;
                if (cp_partial < lowest)
                begin
                    r.code_point = '0;
                    r.status     = u8d_pkg::ST_OVERLONG;
                end
                else
                begin
                    r.code_point = cp_partial;
                    r.status     = u8d_pkg::ST_OK;
                end
                cp_partial = '0;
                seq_total  = '0;
            end
        end
        if (emitted)
            decodes_due.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one byte, idling first at the phase's rate, and hold it until the
    // block takes it. Acceptance is judged at the falling edge, where both
    // valid and stall have settled, and takes effect at the next rising edge.
    task automatic send_byte(input logic [7:0] b);
        bit taken;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do
        begin
            @(negedge clk);
            taken = (in_stall == 1'b0);
            @(posedge clk);
        end
        while (!taken);
        decode_next_byte(b);
        bytes_sent++;
    endtask

    // Encode a value as a sequence of the given length (overlong forms are
    // allowed). With broken_at nonzero, send only that many good bytes and
    // then a byte that is not a continuation.
    task automatic send_sequence(input int len, input logic [30:0] value, input int broken_at);
        logic [7:0] prefix;
        logic [7:0] bad;
        int         k;
        int         sent;
        prefix = (len == 1) ? 8'h00 : 8'(8'hFF << (8 - len));
        send_byte(prefix | 8'(value >> (6 * (len - 1))));
        sent = 1;
        for (k = len - 2; k >= 0; k--)
        begin
            if (broken_at != 0 && sent == broken_at)
            begin
                bad = 8'($urandom_range(255));
                if (bad[7:6] == 2'b10)
                    bad[6] = 1'b1;
                send_byte(bad);
                return;
            end
            send_byte(8'h80 | 8'((value >> (6 * k)) & 32'h3F));
            sent++;
        end
    endtask

    // Random value that fits a sequence of the given length; overlong picks
    // a value below the smallest one that needs that length.
    function automatic logic [30:0] random_value(input int len, input bit overlong);
        int unsigned top;
        int unsigned floor_val;
        top = (len == 1) ? 32'h7F : ((32'd1 << (5 * len + 1)) - 32'd1);
        case (len)
            2:       floor_val = 32'h0000_0080;
            3:       floor_val = 32'h0000_0800;
            4:       floor_val = 32'h0001_0000;
            5:       floor_val = 32'h0020_0000;
            6:       floor_val = 32'h0400_0000;
            default: floor_val = 32'h0;
        endcase
        if (overlong && floor_val != 0)
            return 31'($urandom_range(floor_val - 1, 0));
        return 31'($urandom_range(top, floor_val));
    endfunction

    // Drop valid and wait until every predicted result has come out.
    task automatic wait_for_decodes();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (decodes_due.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // Receiver: stall at the phase's rate, or hold off for a long stretch
    // when a test asks for it.
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    task automatic report_field(input string field, input int unsigned want,
                                input int unsigned got);
        mismatch_count++;
        $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
    endtask

    // Check every result beat against the oldest prediction. Sample at the
    // falling edge so the comparison never races the block's own updates.
    always @(negedge clk)
    begin : check_results
        u8d_pkg::dec_result_t want;
        if (out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (decodes_due.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result: expected none, got cp %h len %0d st %0d",
                         $time, code_point, seq_length, status);
            end
            else
            begin
                want = decodes_due[0];
                decodes_due.delete(0);
                if (code_point !== want.code_point)
                    report_field("code_point", want.code_point, code_point);
                if (seq_length !== want.seq_length)
                    report_field("seq_length", want.seq_length, seq_length);
                if (status !== 2'(want.status))
                    report_field("status", 2'(want.status), status);
            end
        end
    end

    // Watchdog: any beat on either channel resets the count.
    always @(negedge clk)
    begin
        if ((in_valid === 1'b1 && in_stall === 1'b0) ||
            (out_valid === 1'b1 && out_stall === 1'b0))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // ASCII at both ends, then bytes that can never start a sequence.
    task automatic test_single_byte_and_bad_lead();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(8'h80);
        send_byte(8'hFE);
        send_byte(8'hFF);
    endtask

    // Largest code point and the smallest legal six-byte value.
    task automatic test_extreme_values();
        send_sequence(6, 31'h7FFF_FFFF, 0);
        send_sequence(6, 31'h0400_0000, 0);
    endtask

    // Overlong two-byte form, a continuation replaced by a lead byte (which
    // must be swallowed), and ASCII right after to show the decoder resynced.
    task automatic test_error_sequences();
        send_byte(8'hC1);
        send_byte(8'hBF);
        send_byte(8'hE2);
        send_byte(8'h82);
        send_byte(8'hC3);
        send_byte(8'h41);
    endtask

    // Mostly well-formed sequences with random content, some broken ones,
    // and raw noise bytes.
    task automatic test_random_stream(input int idle_pct, input int stall_pct, input int count);
        int stop_at;
        int pick;
        int len;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at)
        begin
            pick = $urandom_range(99);
            len  = $urandom_range(6, 1);
            if (pick < 72)
                send_sequence(len, random_value(len, $urandom_range(9) == 0), 0);
            else if (pick < 86)
            begin
                len = $urandom_range(6, 2);
                send_sequence(len, random_value(len, 1'b0), $urandom_range(len - 1, 1));
            end
            else
                send_byte(8'($urandom_range(255)));
        end
    endtask

    // Hold the receiver off while the sender keeps offering ASCII, so both
    // output entries fill and the block must stall its input.
    task automatic test_backpressure();
        int n;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_request       = 1'b1;
        for (n = 0; n < 40; n++)
            send_byte(8'($urandom_range(127)));
        wait_for_decodes();
    endtask

    // Pause the sender mid-run until the block has drained, then resume.
    task automatic test_pause_until_drained();
        sender_idle_pct    = 0;
        receiver_stall_pct = 76;
        send_sequence(4, random_value(4, 1'b0), 0);
        send_sequence(3, random_value(3, 1'b0), 0);
        wait_for_decodes();
        send_sequence(5, random_value(5, 1'b0), 0);
        send_byte(8'h5A);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_byte_and_bad_lead();
        test_extreme_values();
        test_error_sequences();
        test_random_stream(0, 0, 330);
        test_random_stream(76, 0, 330);
        test_random_stream(0, 76, 330);
        test_random_stream(14, 14, 300);
        test_backpressure();
        test_pause_until_drained();

        // Flush: stop stalling, collect what is owed, then watch for strays.
        receiver_stall_pct = 0;
        wait_for_decodes();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
hw/rtl/u8d_pkg.sv
hw/rtl/u8d_step.sv
hw/rtl/utf8_stream_decoder_top.sv
tb/utf8_stream_decoder_top_test.sv
